/* hw/rtl/ntr_pkg.sv */
package ntr_pkg;

    localparam int ENTRIES   = 128;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_WORDS = 4;
    localparam int WORD_W    = 64;
    localparam int KEY_W     = KEY_WORDS * WORD_W;
    localparam int ROOT_W    = 31;
    localparam int COUNT_W   = 8;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;

    // stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = KEY_W + ROOT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ROOT_W + COUNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } st_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ROOT_W-1:0] root;
    } record_t;

endpackage

/* hw/rtl/ntr_cell.sv */
module ntr_cell (
    input  logic             aclk,
    input  logic             shift_en,
    input  ntr_pkg::record_t shift_in,
    input  logic             load_en,
    input  ntr_pkg::record_t load_data,
    output ntr_pkg::record_t rec_q
);
    import ntr_pkg::*;

    record_t rec_reg;

    // shift has priority: a direct load only happens outside a scan pass
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            rec_reg <= shift_in;
        end else if (load_en) begin
            rec_reg <= load_data;
        end
    end

    assign rec_q = rec_reg;

endmodule

/* hw/rtl/name_to_root_id_table.sv */
// Channel | Dir | Ports                        | Contents
// s_      | in  | tvalid tready tdata tuser    | one table request
// m_      | out | tvalid tready tdata tuser    | one result per request
//
// Records sit in a ring of ENTRIES cells that rotates one position per cycle during a scan;
// the head cell feeds the only key comparator, and the tail takes the
// recirculated, updated or newly inserted record.
// A request passes one full ring rotation in S_SCAN, a commit in S_FIN and the
// load of the output register in S_DONE before its result appears.
// Delete fills the hole with the last record by a direct load in the commit cycle.
// A stalled result holds in the output register; the next request is taken
// meanwhile and its result waits until the register is free.
// Reset (aresetn low, synchronous) empties the table; no clearing pass.
module name_to_root_id_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // name_word0, name_word1, name_word2, name_word3, root_page, zero pad
    input  logic [ntr_pkg::S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic [ntr_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found_root, entry_count, zero pad
    output logic [ntr_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic [ntr_pkg::STATUS_W-1:0]  m_tuser
);
    import ntr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_DONE
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    step_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    hidx_reg;
    logic [ROOT_W-1:0]   froot_reg;
    record_t             last_reg;
    st_t                 res_status_reg;
    logic [ROOT_W-1:0]   res_root_reg;
    logic                m_tvalid_reg;
    st_t                 m_status_reg;
    logic [ROOT_W-1:0]   m_root_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    record_t             cell_q [ENTRIES];
    record_t             head;
    record_t             tail;
    logic [CNT_W-1:0]    step_ext;
    logic                in_range;
    logic                hit;
    logic                grab_last;
    logic                shift_en;
    logic                load_all;

    assign head      = cell_q[0];
    assign step_ext  = CNT_W'(step_reg);
    assign in_range  = step_ext < cnt_reg;
    assign hit       = in_range && (head.key == key_reg);
    assign grab_last = (cnt_reg != '0) && (step_ext == cnt_reg - CNT_W'(1));
    assign shift_en  = (state_reg == S_SCAN);
    assign load_all  = (state_reg == S_FIN) && (op_reg == OP_DELETE) && found_reg;

    // record written back at the tail while the ring turns
    always_comb begin
        tail = head;
        if (op_reg == OP_UPDATE && hit) begin
            tail.root = root_reg;
        end
        // first free slot passes the head; duplicates are already known here
        if (op_reg == OP_INSERT && !found_reg && step_ext == cnt_reg) begin
            tail.key  = key_reg;
            tail.root = root_reg;
        end
    end

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        record_t shift_in;
        if (k == ENTRIES - 1) begin : g_tail
            assign shift_in = tail;
        end else begin : g_link
            assign shift_in = cell_q[k+1];
        end
        ntr_cell u_cell (
            .aclk      (aclk),
            .shift_en  (shift_en),
            .shift_in  (shift_in),
            .load_en   (load_all && (hidx_reg == IDX_W'(k))),
            .load_data (last_reg),
            .rec_q     (cell_q[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // S_DONE handles its own output handshake
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= op_t'(s_tuser);
                        key_reg   <= s_tdata[KEY_W-1:0];
                        root_reg  <= s_tdata[KEY_W +: ROOT_W];
                        step_reg  <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        found_reg <= 1'b1;
                        hidx_reg  <= step_reg;
                        froot_reg <= head.root;
                    end
                    if (grab_last) begin
                        last_reg <= head;
                    end
                    step_reg <= step_reg + IDX_W'(1);
                    if (step_reg == IDX_W'(ENTRIES - 1)) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    res_root_reg <= '0;
                    unique case (op_reg)
                        OP_INSERT: begin
                            if (found_reg) begin
                                res_status_reg <= ST_DUPLICATE;
                            end else if (cnt_reg == CNT_W'(ENTRIES)) begin
                                res_status_reg <= ST_FULL;
                            end else begin
                                res_status_reg <= ST_OK;
                                cnt_reg        <= cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (found_reg) begin
                                res_status_reg <= ST_OK;
                                cnt_reg        <= cnt_reg - CNT_W'(1);
                            end else begin
                                res_status_reg <= ST_NOT_FOUND;
                            end
                        end
                        OP_UPDATE: begin
                            res_status_reg <= found_reg ? ST_OK : ST_NOT_FOUND;
                        end
                        OP_LOOKUP: begin
                            if (found_reg) begin
                                res_status_reg <= ST_OK;
                                res_root_reg   <= froot_reg;
                            end else begin
                                res_status_reg <= ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            res_status_reg <= ST_NOT_FOUND;
                        end
                    endcase
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_root_reg   <= res_root_reg;
                        m_count_reg  <= COUNT_W'(cnt_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, m_count_reg, m_root_reg};

endmodule

/* hw/rtl/ntr_check.sv */
module ntr_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ntr_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ntr_pkg::STATUS_W-1:0]  m_tuser
);
    import ntr_pkg::*;

    // one request in flight: input closes right after a request is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // a result never follows its request in the next cycle
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared before the table scan finished");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> m_tdata[ROOT_W +: COUNT_W] == COUNT_W'(ENTRIES))
        else $error("table full reported below capacity");

    a_root_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[ROOT_W-1:0] != '0 |-> m_tuser == ST_OK)
        else $error("nonzero root on a failed request");

endmodule

bind name_to_root_id_table ntr_check u_ntr_check (.*);
